// ===== sv/assert_macros.svh =====
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/wrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// wrhp_pkg
// types and constants shared by the wav riff header parser modules
// ----------------------------------------------------------------------------
`default_nettype none

package wrhp_pkg;

   // chunk tags as they arrive, first byte in the top bits
   localparam logic [31:0] TAG_FMT     = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA    = 32'h6461_7461;
   localparam logic [31:0] FMT_MIN_LEN = 32'd16;

   localparam logic [15:0] FMT_PCM     = 16'd1;
   localparam logic [15:0] PCM_BITS    = 16'd16;

   // riff header layout
   localparam logic [3:0] RIFF_HDR_LEN  = 4'd12;
   localparam logic [3:0] RIFF_SIZE_LO  = 4'd4;
   localparam logic [3:0] RIFF_SIZE_END = 4'd8;
   localparam logic [3:0] CHDR_TAG_END  = 4'd4;
   localparam logic [3:0] CHDR_LEN      = 4'd8;
   localparam logic [4:0] FMT_BODY_LEN  = 5'd16;

   // status codes
   localparam logic [2:0] ST_PARSING     = 3'd0;
   localparam logic [2:0] ST_PAYLOAD     = 3'd1;
   localparam logic [2:0] ST_NOT_WAV     = 3'd2;
   localparam logic [2:0] ST_SHORT_FMT   = 3'd3;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
   localparam logic [2:0] ST_CHANNELS    = 3'd5;
   localparam logic [2:0] ST_DATA_EARLY  = 3'd6;
   localparam logic [2:0] ST_NO_DATA     = 3'd7;

   // byte kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_DISCARD = 2'd2;

   // one word on its way from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       tag_fmt;   // this byte closes a "fmt " window
      logic       tag_data;  // this byte closes a "data" window
   } item_type;

   // expected riff header byte, bytes 4 to 7 are not checked
   function automatic logic [7:0] riff_expect(input logic [3:0] idx);
      logic [7:0] res;
      unique case (idx)
         4'd0:    res = 8'h52;
         4'd1:    res = 8'h49;
         4'd2:    res = 8'h46;
         4'd3:    res = 8'h46;
         4'd8:    res = 8'h57;
         4'd9:    res = 8'h41;
         4'd10:   res = 8'h56;
         4'd11:   res = 8'h45;
         default: res = 8'h00;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== sv/wrhp_front.sv =====
// ----------------------------------------------------------------------------
// wrhp_front
// input register, tags words that close a "fmt " or "data" tag window
// ----------------------------------------------------------------------------
`default_nettype none

module wrhp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tlast,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output wrhp_pkg::item_type     out_item
);
   import wrhp_pkg::*;

   logic             valid_ff;
   item_type         item_ff;
   item_type         item_in;
   logic [23:0]      hist_ff;
   logic             accept;

   assign req_tready = !valid_ff || out_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item_in.data     = req_tdata;
      item_in.last     = req_tlast;
      item_in.tag_fmt  = ({hist_ff, req_tdata} == TAG_FMT);
      item_in.tag_data = ({hist_ff, req_tdata} == TAG_DATA);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
      if (accept) begin
         item_ff <= item_in;
         hist_ff <= {hist_ff[15:0], req_tdata};
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ===== sv/wrhp_queue.sv =====
// ----------------------------------------------------------------------------
// wrhp_queue
// short flop queue between the front and the parser
// ----------------------------------------------------------------------------
`default_nettype none

module wrhp_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire wrhp_pkg::item_type push_item,
   output logic                   push_ready,
   input  wire logic              pop,
   output logic                   pop_valid,
   output wrhp_pkg::item_type     pop_item
);
   import wrhp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_push;
   logic            do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== sv/wrhp_back.sv =====
// ----------------------------------------------------------------------------
// wrhp_back
// riff / fmt / chunk walker with the result register
// ----------------------------------------------------------------------------
`default_nettype none

module wrhp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_pop,
   input  wire wrhp_pkg::item_type in_item,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_byte,
   output logic [1:0]              rsp_kind,
   output logic [2:0]              rsp_status,
   output logic [1:0]              rsp_channels,
   output logic [31:0]             rsp_rate,
   output logic                    rsp_done
);
   import wrhp_pkg::*;

   typedef enum logic [2:0] {
      PH_RIFF, PH_CHDR, PH_FMT, PH_SKIP, PH_DATA, PH_ERR
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  header_count_ff, header_count_in;
   logic        tag_fmt_ff, tag_fmt_in;
   logic        tag_data_ff, tag_data_in;
   logic [31:0] chunk_length_ff, chunk_length_in;
   logic [32:0] skip_remaining_ff, skip_remaining_in;
   logic [4:0]  fmt_position_ff, fmt_position_in;
   logic [15:0] format_code_ff, format_code_in;
   logic [15:0] sample_bits_ff, sample_bits_in;
   logic [15:0] staged_channels_ff, staged_channels_in;
   logic [31:0] staged_rate_ff, staged_rate_in;
   logic [1:0]  channel_word_ff, channel_word_in;
   logic [31:0] rate_word_ff, rate_word_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic [2:0]  status_reg_ff, status_reg_in;

   logic        valid_ff;
   logic [7:0]  byte_ff;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  st_ff, st_in;
   logic [1:0]  chan_ff;
   logic [31:0] rate_ff;
   logic        done_ff;

   logic [7:0]  b;
   logic [3:0]  hc_inc;
   logic [4:0]  pos_inc;
   logic [31:0] len_body;
   logic [32:0] skip_chunk;
   logic [32:0] skip_fmt;

   assign in_pop = in_valid && (!valid_ff || rsp_tready);
   assign b      = in_item.data;

   always_comb begin
      hc_inc     = header_count_ff + 4'd1;
      pos_inc    = fmt_position_ff + 5'd1;
      len_body   = chunk_length_ff - FMT_MIN_LEN;
      skip_fmt   = {1'b0, len_body} + 33'(chunk_length_ff[0]);

      phase_in           = phase_ff;
      header_count_in    = header_count_ff;
      tag_fmt_in         = tag_fmt_ff;
      tag_data_in        = tag_data_ff;
      chunk_length_in    = chunk_length_ff;
      skip_remaining_in  = skip_remaining_ff;
      fmt_position_in    = fmt_position_ff;
      format_code_in     = format_code_ff;
      sample_bits_in     = sample_bits_ff;
      staged_channels_in = staged_channels_ff;
      staged_rate_in     = staged_rate_ff;
      channel_word_in    = channel_word_ff;
      rate_word_in       = rate_word_ff;
      fmt_seen_in        = fmt_seen_ff;
      status_reg_in      = status_reg_ff;

      if (header_count_ff >= CHDR_TAG_END) begin
         chunk_length_in = {b, chunk_length_ff[31:8]};
      end
      skip_chunk = {1'b0, chunk_length_in} + 33'(chunk_length_in[0]);

      unique case (phase_ff)
         PH_RIFF: begin
            if ((header_count_ff < RIFF_SIZE_LO || header_count_ff >= RIFF_SIZE_END) &&
                b != riff_expect(header_count_ff)) begin
               phase_in      = PH_ERR;
               status_reg_in = ST_NOT_WAV;
            end else if (hc_inc >= RIFF_HDR_LEN) begin
               header_count_in = '0;
               phase_in        = PH_CHDR;
            end else begin
               header_count_in = hc_inc;
            end
            chunk_length_in = chunk_length_ff;
         end
         PH_CHDR: begin
            if (header_count_ff == CHDR_TAG_END - 4'd1) begin
               tag_fmt_in  = in_item.tag_fmt;
               tag_data_in = in_item.tag_data;
            end
            header_count_in = hc_inc;
            if (hc_inc == CHDR_LEN) begin
               header_count_in = '0;
               if (tag_fmt_ff) begin
                  if (chunk_length_in < FMT_MIN_LEN) begin
                     phase_in      = PH_ERR;
                     status_reg_in = ST_SHORT_FMT;
                  end else begin
                     phase_in           = PH_FMT;
                     fmt_position_in    = '0;
                     format_code_in     = '0;
                     sample_bits_in     = '0;
                     staged_channels_in = '0;
                     staged_rate_in     = '0;
                  end
               end else if (tag_data_ff) begin
                  if (!fmt_seen_ff) begin
                     phase_in      = PH_ERR;
                     status_reg_in = ST_DATA_EARLY;
                  end else begin
                     phase_in      = PH_DATA;
                     status_reg_in = ST_PAYLOAD;
                  end
               end else begin
                  skip_remaining_in = skip_chunk;
                  phase_in          = (skip_chunk != '0) ? PH_SKIP : PH_CHDR;
               end
            end
         end
         PH_FMT: begin
            chunk_length_in = chunk_length_ff;
            case (fmt_position_ff)
               5'd0:  format_code_in[7:0]      = b;
               5'd1:  format_code_in[15:8]     = b;
               5'd2:  staged_channels_in[7:0]  = b;
               5'd3:  staged_channels_in[15:8] = b;
               5'd4:  staged_rate_in[7:0]      = b;
               5'd5:  staged_rate_in[15:8]     = b;
               5'd6:  staged_rate_in[23:16]    = b;
               5'd7:  staged_rate_in[31:24]    = b;
               5'd14: sample_bits_in[7:0]      = b;
               5'd15: sample_bits_in[15:8]     = b;
               default: ;
            endcase
            fmt_position_in = pos_inc;
            if (pos_inc == FMT_BODY_LEN) begin
               if (format_code_in != FMT_PCM || sample_bits_in != PCM_BITS) begin
                  phase_in      = PH_ERR;
                  status_reg_in = ST_UNSUPPORTED;
               end else if (staged_channels_in < 16'd1 || staged_channels_in > 16'd2) begin
                  phase_in      = PH_ERR;
                  status_reg_in = ST_CHANNELS;
               end else begin
                  channel_word_in   = staged_channels_in[1:0];
                  rate_word_in      = staged_rate_in;
                  fmt_seen_in       = 1'b1;
                  skip_remaining_in = skip_fmt;
                  header_count_in   = '0;
                  phase_in          = (skip_fmt != '0) ? PH_SKIP : PH_CHDR;
               end
            end
         end
         PH_SKIP: begin
            chunk_length_in   = chunk_length_ff;
            skip_remaining_in = skip_remaining_ff - 33'd1;
            if (skip_remaining_in == '0) begin
               phase_in = PH_CHDR;
            end
         end
         default: begin
            chunk_length_in = chunk_length_ff;
         end
      endcase

      // result fields come from the updated state, the payload kind from the old phase
      st_in = status_reg_in;
      if (in_item.last && st_in == ST_PARSING) begin
         if (phase_in == PH_RIFF) begin
            st_in = ST_NOT_WAV;
         end else if (phase_in == PH_FMT) begin
            st_in = ST_SHORT_FMT;
         end else begin
            st_in = ST_NO_DATA;
         end
      end
      if (st_in >= ST_NOT_WAV) begin
         kind_in = KIND_DISCARD;
      end else if (phase_ff == PH_DATA) begin
         kind_in = KIND_PAYLOAD;
      end else begin
         kind_in = KIND_HEADER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff           <= 1'b0;
         phase_ff           <= PH_RIFF;
         header_count_ff    <= '0;
         tag_fmt_ff         <= 1'b0;
         tag_data_ff        <= 1'b0;
         chunk_length_ff    <= '0;
         skip_remaining_ff  <= '0;
         fmt_position_ff    <= '0;
         format_code_ff     <= '0;
         sample_bits_ff     <= '0;
         staged_channels_ff <= '0;
         staged_rate_ff     <= '0;
         channel_word_ff    <= '0;
         rate_word_ff       <= '0;
         fmt_seen_ff        <= 1'b0;
         status_reg_ff      <= ST_PARSING;
      end else begin
         if (in_pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
         if (in_pop && in_item.last) begin
            // file closed, back to the riff header
            phase_ff           <= PH_RIFF;
            header_count_ff    <= '0;
            tag_fmt_ff         <= 1'b0;
            tag_data_ff        <= 1'b0;
            chunk_length_ff    <= '0;
            skip_remaining_ff  <= '0;
            fmt_position_ff    <= '0;
            format_code_ff     <= '0;
            sample_bits_ff     <= '0;
            staged_channels_ff <= '0;
            staged_rate_ff     <= '0;
            channel_word_ff    <= '0;
            rate_word_ff       <= '0;
            fmt_seen_ff        <= 1'b0;
            status_reg_ff      <= ST_PARSING;
         end else if (in_pop) begin
            phase_ff           <= phase_in;
            header_count_ff    <= header_count_in;
            tag_fmt_ff         <= tag_fmt_in;
            tag_data_ff        <= tag_data_in;
            chunk_length_ff    <= chunk_length_in;
            skip_remaining_ff  <= skip_remaining_in;
            fmt_position_ff    <= fmt_position_in;
            format_code_ff     <= format_code_in;
            sample_bits_ff     <= sample_bits_in;
            staged_channels_ff <= staged_channels_in;
            staged_rate_ff     <= staged_rate_in;
            channel_word_ff    <= channel_word_in;
            rate_word_ff       <= rate_word_in;
            fmt_seen_ff        <= fmt_seen_in;
            status_reg_ff      <= status_reg_in;
         end
      end
      if (in_pop) begin
         byte_ff <= b;
         kind_ff <= kind_in;
         st_ff   <= st_in;
         chan_ff <= channel_word_in;
         rate_ff <= rate_word_in;
         done_ff <= in_item.last;
      end
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_byte     = byte_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_status   = st_ff;
   assign rsp_channels = chan_ff;
   assign rsp_rate     = rate_ff;
   assign rsp_done     = done_ff;

endmodule

`default_nettype wire

// ===== sv/wav_riff_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// wav_riff_header_parser_core
// streaming wav riff header parser, one result word per file byte
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one file byte per word, req_tlast on the final byte.
//   rsp channel returns one word per byte: the byte, its kind (header,
//   payload, discarded), the status, channel count and sample rate of the
//   latest accepted fmt chunk, with rsp_tlast marking the final byte.
//   on the final word the status is final, and the parser returns to the
//   riff header for the next file.
// path: with no stall a byte moves from the front register to a queue entry
//   and then to the result register, which raises rsp_tvalid.
// throughput: one word per cycle while rsp_tready stays high; the chunk walker
//   in the back end updates its state once per byte and the front keeps taking
//   words while a result waits, until the front register and the queue are full.
// reset: synchronous, clears the queue, the result valid and all parse state.
// stall: when rsp_tready is low the result holds, the back end stops popping,
//   and req_tready drops once QUEUE_DEPTH + 2 words are pending (result
//   register, queue, front register).
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wav_riff_header_parser_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   input  wire logic        req_tlast,   // last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [7:0] byte_out, [10:8] status,
                                         // [12:11] channel_count,
                                         // [44:13] rate, [47:45] zero
   output logic [1:0]       rsp_tuser,   // [1:0] byte_kind
   output logic             rsp_tlast    // done_res
);
   import wrhp_pkg::*;

   // front to queue
   logic       fr_valid;
   logic       q_ready;
   item_type   fr_item;

   // queue to back
   logic       q_valid;
   logic       q_pop;
   item_type   q_item;

   // back result fields
   logic [7:0]  res_byte;
   logic [2:0]  res_status;
   logic [1:0]  res_channels;
   logic [31:0] res_rate;

   wrhp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .out_valid  (fr_valid),
      .out_ready  (q_ready),
      .out_item   (fr_item)
   );

   // decouples classification from the chunk walker
   wrhp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fr_valid),
      .push_item  (fr_item),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_item   (q_item)
   );

   wrhp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_valid),
      .in_pop       (q_pop),
      .in_item      (q_item),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_byte     (res_byte),
      .rsp_kind     (rsp_tuser),
      .rsp_status   (res_status),
      .rsp_channels (res_channels),
      .rsp_rate     (res_rate),
      .rsp_done     (rsp_tlast)
   );

   // pack result fields, lowest field first, zero fill to whole bytes
   assign rsp_tdata = {3'b000, res_rate, res_channels, res_status, res_byte};

   // the final word of a file never reports parsing in progress
   `ASSERT_IMPLY(a_final_status, clock, reset, rsp_tvalid && rsp_tlast,
      res_status != ST_PARSING, "final word carries parsing status")
   // payload bytes only appear with payload status
   `ASSERT_IMPLY(a_payload_status, clock, reset, rsp_tvalid && rsp_tuser == KIND_PAYLOAD,
      res_status == ST_PAYLOAD, "payload byte without payload status")
   // payload implies an accepted fmt chunk
   `ASSERT_IMPLY(a_payload_fmt, clock, reset, rsp_tvalid && rsp_tuser == KIND_PAYLOAD,
      res_channels != 2'd0, "payload byte without channel count")
   // error statuses always discard
   `ASSERT_IMPLY(a_error_kind, clock, reset, rsp_tvalid && res_status >= ST_NOT_WAV,
      rsp_tuser == KIND_DISCARD, "error status on a kept byte")

endmodule

`default_nettype wire

// ===== test/wrhp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrhp_checker
// watches both streams of the wav riff header parser, predicts every result
// word from the accepted file bytes and compares it field by field
// ----------------------------------------------------------------------------

module wrhp_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   input  logic        req_tlast,   // last
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [7:0] byte_out, [10:8] status,
                                    // [12:11] channel_count,
                                    // [44:13] rate, [47:45] zero
   input  logic [1:0]  rsp_tuser,   // [1:0] byte_kind
   input  logic        rsp_tlast,   // done_res
   output int          error_count,
   output int          pending,
   output int          checked_count,
   output logic [7:0]  status_seen
);
   import wrhp_pkg::*;

   localparam int PRINT_CAP = 100;

   // 'R' in the lowest byte, size bytes 4 to 7 are never compared
   localparam logic [95:0] RIFF_MAGIC = {"EVAW", 32'h0, "FFIR"};

   typedef enum logic [2:0] {
      WALK_RIFF,
      WALK_CHUNK_HDR,
      WALK_FMT,
      WALK_SKIP,
      WALK_PAYLOAD,
      WALK_FAILED
   } walk_phase_type;

   typedef struct packed {
      logic [7:0]  data;
      logic [1:0]  kind;
      logic [2:0]  status;
      logic [1:0]  channels;
      logic [31:0] rate;
      logic        done;
   } parsed_word_type;

   parsed_word_type expected_words[$];

   // chunk walker state
   walk_phase_type walk;
   logic [3:0]  hdr_cnt;
   logic [31:0] chunk_tag;
   logic [31:0] chunk_len;
   logic [32:0] skip_left;
   logic [4:0]  fmt_pos;
   logic [15:0] fmt_code;
   logic [15:0] fmt_bits;
   logic [15:0] ch_stage;
   logic [31:0] rate_stage;
   logic [15:0] ch_word;
   logic [31:0] rate_word;
   logic        fmt_ok;
   logic [2:0]  st_reg;

   function automatic void restart_walk();
      walk       = WALK_RIFF;
      hdr_cnt    = '0;
      chunk_tag  = '0;
      chunk_len  = '0;
      skip_left  = '0;
      fmt_pos    = '0;
      fmt_code   = '0;
      fmt_bits   = '0;
      ch_stage   = '0;
      rate_stage = '0;
      ch_word    = '0;
      rate_word  = '0;
      fmt_ok     = 1'b0;
      st_reg     = ST_PARSING;
   endfunction

   function automatic void fail_walk(input logic [2:0] code);
      walk   = WALK_FAILED;
      st_reg = code;
   endfunction

   function automatic void start_skip(input logic [32:0] count);
      skip_left = count;
      walk      = (count != 0) ? WALK_SKIP : WALK_CHUNK_HDR;
      hdr_cnt   = '0;
   endfunction

   function automatic void take_fmt_byte(input logic [7:0] b);
      int p;
      p = fmt_pos;
      if (p < 2)
         fmt_code |= 16'(b) << (8 * p);
      else if (p < 4)
         ch_stage |= 16'(b) << (8 * (p - 2));
      else if (p < 8)
         rate_stage |= 32'(b) << (8 * (p - 4));
      else if (p >= 14 && p < 16)
         fmt_bits |= 16'(b) << (8 * (p - 14));
      fmt_pos = 5'(p + 1);
      if (fmt_pos == FMT_BODY_LEN) begin
         // format and bits are judged before the channel count
         if (fmt_code != FMT_PCM || fmt_bits != PCM_BITS) begin
            fail_walk(ST_UNSUPPORTED);
         end else if (ch_stage < 1 || ch_stage > 2) begin
            fail_walk(ST_CHANNELS);
         end else begin
            ch_word   = ch_stage;
            rate_word = rate_stage;
            fmt_ok    = 1'b1;
            start_skip({1'b0, chunk_len} - 33'(FMT_MIN_LEN) + 33'(chunk_len[0]));
         end
      end
   endfunction

   function automatic void take_header_byte(input logic [7:0] b);
      if (hdr_cnt < CHDR_TAG_END)
         chunk_tag = {chunk_tag[23:0], b};
      else
         chunk_len = {b, chunk_len[31:8]};
      hdr_cnt++;
      if (hdr_cnt == CHDR_LEN) begin
         hdr_cnt = '0;
         if (chunk_tag == TAG_FMT) begin
            if (chunk_len < FMT_MIN_LEN) begin
               fail_walk(ST_SHORT_FMT);
            end else begin
               walk       = WALK_FMT;
               fmt_pos    = '0;
               fmt_code   = '0;
               fmt_bits   = '0;
               ch_stage   = '0;
               rate_stage = '0;
            end
         end else if (chunk_tag == TAG_DATA) begin
            if (!fmt_ok) begin
               fail_walk(ST_DATA_EARLY);
            end else begin
               walk   = WALK_PAYLOAD;
               st_reg = ST_PAYLOAD;
            end
         end else begin
            // unknown chunk, body plus pad byte when odd
            start_skip({1'b0, chunk_len} + 33'(chunk_len[0]));
         end
      end
   endfunction

   function automatic parsed_word_type walk_byte(input logic [7:0] b, input logic fin);
      parsed_word_type w;
      logic [1:0]   kind;
      logic [2:0]   st;
      kind = KIND_HEADER;
      case (walk)
         WALK_RIFF: begin
            if ((hdr_cnt < RIFF_SIZE_LO || hdr_cnt >= RIFF_SIZE_END) &&
                b != RIFF_MAGIC[8 * hdr_cnt +: 8]) begin
               fail_walk(ST_NOT_WAV);
            end else begin
               hdr_cnt++;
               if (hdr_cnt >= RIFF_HDR_LEN) begin
                  hdr_cnt = '0;
                  walk    = WALK_CHUNK_HDR;
               end
            end
         end
         WALK_CHUNK_HDR: take_header_byte(b);
         WALK_FMT:       take_fmt_byte(b);
         WALK_SKIP: begin
            skip_left = skip_left - 33'd1;
            if (skip_left == 0)
               walk = WALK_CHUNK_HDR;
         end
         WALK_PAYLOAD:   kind = KIND_PAYLOAD;
         default: ;
      endcase
      // file ended while still parsing
      st = st_reg;
      if (fin && st == ST_PARSING) begin
         if (walk == WALK_RIFF)
            st = ST_NOT_WAV;
         else if (walk == WALK_FMT)
            st = ST_SHORT_FMT;
         else
            st = ST_NO_DATA;
      end
      if (st >= ST_NOT_WAV)
         kind = KIND_DISCARD;
      w.data     = b;
      w.kind     = kind;
      w.status   = st;
      w.channels = ch_word[1:0];
      w.rate     = rate_word;
      w.done     = fin;
      if (fin)
         restart_walk();
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      // count every mismatch, keep the log short
      if (error_count < PRINT_CAP)
         $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : watch
      parsed_word_type want;
      parsed_word_type next_word;
      if (reset) begin
         expected_words.delete();
         restart_walk();
         error_count   = 0;
         pending       = 0;
         checked_count = 0;
         status_seen   = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked_count++;
            status_seen[rsp_tdata[10:8]] = 1'b1;
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", 32'(rsp_tdata[7:0]), '0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata[7:0] != want.data)
                  report_mismatch("byte_out", 32'(rsp_tdata[7:0]), 32'(want.data));
               if (rsp_tuser != want.kind)
                  report_mismatch("byte_kind", 32'(rsp_tuser), 32'(want.kind));
               if (rsp_tdata[10:8] != want.status)
                  report_mismatch("status", 32'(rsp_tdata[10:8]), 32'(want.status));
               if (rsp_tdata[12:11] != want.channels)
                  report_mismatch("channel_count", 32'(rsp_tdata[12:11]),
                                  32'(want.channels));
               if (rsp_tdata[44:13] != want.rate)
                  report_mismatch("rate", rsp_tdata[44:13], want.rate);
               if (rsp_tdata[47:45] != 3'b000)
                  report_mismatch("tdata fill bits", 32'(rsp_tdata[47:45]), '0);
               if (rsp_tlast != want.done)
                  report_mismatch("done_res", 32'(rsp_tlast), 32'(want.done));
            end
         end
         if (req_tvalid && req_tready) begin
            next_word      = walk_byte(req_tdata, req_tlast);
            expected_words = {expected_words, next_word};
         end
         pending = expected_words.size();
      end
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// feeds whole wav files byte by byte into the riff header parser: a few tiny
// files at the extremes, then generated files covering every status, mostly
// well formed with random content, under random idling on both streams
// ----------------------------------------------------------------------------

module tb;
   import wrhp_pkg::*;

   localparam int BYTE_TARGET  = 390;   // stop starting new files past this
   localparam int STALL_LIMIT  = 2000;  // cycles with no word moving
   localparam int HOLD_CYCLES  = 80;    // one long receiver hold-off
   localparam int HOLD_AT      = 150;   // bytes sent before the hold starts
   localparam int PAUSE_FILE   = 6;     // sender drains the parser before this file
   localparam int DRAIN_CYCLES = 20;

   localparam logic [31:0] RIFF_TAG = "RIFF";
   localparam logic [31:0] WAVE_TAG = "WAVE";
   localparam logic [31:0] LIST_TAG = "LIST";

   // kinds of generated file, each aimed at one outcome of the parse
   typedef enum int {
      F_GOOD,
      F_NOT_WAV,
      F_SHORT_FMT,
      F_BAD_FORMAT,
      F_BAD_CHANNELS,
      F_DATA_EARLY,
      F_NO_DATA,
      F_CUT_FMT,
      F_HUGE_CHUNK,
      F_REFMT,
      F_NOISE,
      F_COUNT
   } file_kind_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] byte_in
   logic        req_tlast;    // last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // [7:0] byte_out, [10:8] status,
                              // [12:11] channel_count, [44:13] rate
   logic [1:0]  rsp_tuser;    // [1:0] byte_kind
   logic        rsp_tlast;    // done_res

   int          error_count;
   int          pending;
   int          checked_count;
   logic [7:0]  status_seen;

   int          bytes_sent;
   int          files_sent;
   logic        calm;         // no idling on either side while set, but the receiver hold-off still wins
   logic [7:0]  file_bytes[$];

   wav_riff_header_parser_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   wrhp_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .error_count   (error_count),
      .pending       (pending),
      .checked_count (checked_count),
      .status_seen   (status_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // file building blocks: the put tasks append to file_bytes, cut_to trims it
   // ---------------------------------------------------------------------

   task automatic put_byte(input logic [7:0] v);
      file_bytes = {file_bytes, v};
   endtask

   task automatic put_random(input int n);
      for (int i = 0; i < n; i++)
         put_byte(8'($urandom));
   endtask

   task automatic put_le16(input logic [15:0] v);
      put_byte(v[7:0]);
      put_byte(v[15:8]);
   endtask

   task automatic put_le32(input logic [31:0] v);
      put_le16(v[15:0]);
      put_le16(v[31:16]);
   endtask

   // tags go out first character first
   task automatic put_tag(input logic [31:0] t);
      for (int i = 3; i >= 0; i--)
         put_byte(t[8 * i +: 8]);
   endtask

   task automatic put_riff(input logic [31:0] size);
      put_tag(RIFF_TAG);
      put_le32(size);
      put_tag(WAVE_TAG);
   endtask

   // any chunk tag that the parser must skip
   function automatic logic [31:0] other_tag();
      logic [31:0] t;
      t = $urandom_range(0, 1) ? LIST_TAG : $urandom;
      if (t == TAG_FMT || t == TAG_DATA)
         t ^= 32'h1;
      return t;
   endfunction

   // fmt chunk: format, channels, rate, byte rate, block align, bits, extra
   task automatic put_fmt(input logic [15:0] code, input logic [15:0] chans,
                          input logic [31:0] rate, input logic [15:0] bits,
                          input int extra);
      put_tag(TAG_FMT);
      put_le32(FMT_MIN_LEN + 32'(extra));
      put_le16(code);
      put_le16(chans);
      put_le32(rate);
      put_le32($urandom);
      put_le16(16'($urandom));
      put_le16(bits);
      put_random(extra + extra % 2);   // odd length gets a pad byte
   endtask

   task automatic put_good_fmt();
      put_fmt(FMT_PCM, 16'($urandom_range(1, 2)), $urandom, PCM_BITS,
              $urandom_range(0, 3));
   endtask

   task automatic put_other(input int len);
      put_tag(other_tag());
      put_le32(32'(len));
      put_random(len + len % 2);
   endtask

   task automatic put_data_header();
      put_tag(TAG_DATA);
      put_le32($urandom);   // data length is never used by the parser
   endtask

   task automatic cut_to(input int n);
      while (file_bytes.size() > n)
         void'(file_bytes.pop_back());
   endtask

   task automatic build_file(input file_kind_type kind);
      logic [15:0] code;
      logic [15:0] bits;
      int          pos;
      file_bytes.delete();
      case (kind)
         F_GOOD: begin
            put_riff($urandom);
            if ($urandom_range(0, 1)) put_other($urandom_range(0, 5));
            put_good_fmt();
            if ($urandom_range(0, 1)) put_other($urandom_range(0, 5));
            put_data_header();
            put_random($urandom_range(0, 8));   // zero means empty payload
         end
         F_NOT_WAV: begin
            put_riff($urandom);
            if ($urandom_range(0, 1)) begin
               // spoil one checked byte of the riff header
               pos = $urandom_range(0, 7);
               pos = (pos < 4) ? pos : pos + 4;
               file_bytes[pos] ^= 8'($urandom_range(1, 255));
               put_random($urandom_range(0, 3));
            end else begin
               cut_to($urandom_range(1, 11));   // file ends inside the header
            end
         end
         F_SHORT_FMT: begin
            put_riff($urandom);
            put_tag(TAG_FMT);
            put_le32($urandom_range(0, 15));
            put_random($urandom_range(0, 3));
         end
         F_BAD_FORMAT: begin
            code = $urandom_range(0, 1) ? FMT_PCM : 16'($urandom);
            bits = $urandom_range(0, 1) ? PCM_BITS : 16'($urandom);
            if (code == FMT_PCM && bits == PCM_BITS)
               bits ^= 16'($urandom_range(1, 65535));
            put_riff($urandom);
            put_fmt(code, 16'($urandom), $urandom, bits, $urandom_range(0, 3));
            put_random($urandom_range(0, 3));
         end
         F_BAD_CHANNELS: begin
            put_riff($urandom);
            put_fmt(FMT_PCM, $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(3, 65535)),
                    $urandom, PCM_BITS, $urandom_range(0, 3));
            put_random($urandom_range(0, 3));
         end
         F_DATA_EARLY: begin
            put_riff($urandom);
            if ($urandom_range(0, 1)) put_other($urandom_range(0, 5));
            put_data_header();
            put_random($urandom_range(0, 3));
         end
         F_NO_DATA: begin
            put_riff($urandom);
            put_good_fmt();
            put_other($urandom_range(0, 5));
            cut_to($urandom_range(13, file_bytes.size()));
         end
         F_CUT_FMT: begin
            // ends anywhere from right after the fmt header to one byte short
            put_riff($urandom);
            put_good_fmt();
            cut_to(20 + $urandom_range(0, 15));
         end
         F_HUGE_CHUNK: begin
            // skip count from 2^31 up to 2^32 in the 33-bit counter, file ends long before it runs out
            put_riff($urandom);
            put_good_fmt();
            put_tag(other_tag());
            case ($urandom_range(0, 2))
               0:       put_le32(32'hFFFF_FFFF);
               1:       put_le32(32'hFFFF_FFFE);
               default: put_le32($urandom | 32'h8000_0000);
            endcase
            put_random($urandom_range(1, 6));
         end
         F_REFMT: begin
            // the second fmt chunk must be the one reported
            put_riff($urandom);
            put_good_fmt();
            put_good_fmt();
            put_data_header();
            put_random($urandom_range(0, 2));
         end
         default: put_random($urandom_range(1, 16));
      endcase
   endtask

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   // one byte: maybe idle a little, then offer it until the parser takes it
   task automatic send_byte(input logic [7:0] b, input logic fin);
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_file();
      calm = (files_sent >= 9 && files_sent < 12);
      if (files_sent == PAUSE_FILE) begin
         // let every outstanding word come back before the next file
         @(negedge clock);
         req_tvalid <= 1'b0;
         while (pending != 0)
            @(negedge clock);
      end
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      files_sent++;
   endtask

   // ---------------------------------------------------------------------
   // response side: random back pressure plus one long hold-off so that the
   // parser's queue fills and req_tready drops
   // ---------------------------------------------------------------------
   initial begin : receiver
      int hold_left;
      bit held;
      hold_left  = 0;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && bytes_sent >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 7);
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: ends the run when no word moves for too long
   // ---------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus and verdict
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int            r;
      file_kind_type pick;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      calm       = 1'b0;
      bytes_sent = 0;
      files_sent = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tiny files: lone all-zero and all-one bytes, a bare riff header with
      // extreme size bytes, and a wrong first byte followed by more bytes
      file_bytes.delete();
      put_byte(8'h00);
      send_file();
      file_bytes.delete();
      put_byte(8'hFF);
      send_file();
      file_bytes.delete();
      put_riff(32'h00FF_00FF);
      send_file();
      file_bytes.delete();
      put_byte(8'h58);
      put_byte(8'hFF);
      put_byte(8'h00);
      put_byte(8'h52);
      send_file();

      // one of each kind, then a random mix weighted toward good files
      for (int k = 0; k < F_COUNT; k++) begin
         build_file(file_kind_type'(k));
         send_file();
      end
      while (bytes_sent < BYTE_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 40)
            pick = F_GOOD;
         else if (r < 55)
            pick = F_REFMT;
         else
            pick = file_kind_type'($urandom_range(0, F_COUNT - 1));
         build_file(pick);
         send_file();
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      // anything arriving now has no expectation and is flagged by the checker
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run covered %0d files and %0d bytes, %0d result words checked",
               files_sent, bytes_sent, checked_count);
      $display("status codes returned (bit per code, 7 down to 0): %b", status_seen);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
